/* rtl/prnf_pkg.sv */
// Package: widths, constants, types and arithmetic helpers for the pole-residue noise filter.
package prnf_pkg;

	localparam int MAX_POLES  = 16;
	localparam int IDX_W      = $clog2(MAX_POLES);
	localparam int CNT_W      = 5;
	localparam int COEF_WIDTH = 32;
	localparam int COEF_FRAC  = 24;
	localparam int ACC_W      = 72;

	typedef logic signed [31:0] word_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		word_t a_re; word_t a_im;
		word_t b_re; word_t b_im;
		word_t c_re; word_t c_im;
		word_t r_re; word_t r_im;
	} coef_t;

	typedef struct packed {
		word_t re;
		word_t im;
	} cpx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_UPDATE,
		ST_RESID,
		ST_DONE
	} state_t;

	// sign-extend low COEF_WIDTH bits
	function automatic word_t coef_ext(input logic [31:0] v);
		logic [31:0] m;
		logic [31:0] x;
		m = 32'(1) << (COEF_WIDTH - 1);
		x = (COEF_WIDTH >= 32) ? v : (v & (m + m - 32'd1));
		return word_t'((x ^ m) - m);
	endfunction

	// round half up from 2^-40 units to Q16.16 and flag clipping
	function automatic cpx_t round_sat(input acc_t s);
		acc_t t;
		cpx_t r;
		t = (s + (acc_t'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		r.im = '0;
		if (t > acc_t'(32'sh7fffffff)) begin
			r.re = 32'sh7fffffff; r.im = 32'sd1;
		end else if (t < -acc_t'(33'sh080000000)) begin
			r.re = 32'sh80000000; r.im = 32'sd1;
		end else begin
			r.re = t[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/prnf_mem.sv */
// Coefficient and pole-state memories with registered reads.
module prnf_mem (
	input  logic                     clk,
	input  logic                     coef_we,
	input  logic [prnf_pkg::IDX_W-1:0] coef_waddr,
	input  prnf_pkg::coef_t          coef_wdata,
	input  logic                     st_we,
	input  logic [prnf_pkg::IDX_W-1:0] st_waddr,
	input  prnf_pkg::cpx_t           st_wdata,
	input  logic [prnf_pkg::IDX_W-1:0] raddr,
	output prnf_pkg::coef_t          coef_rdata,
	output prnf_pkg::cpx_t           st_rdata
);
	prnf_pkg::coef_t coef_mem [prnf_pkg::MAX_POLES];
	prnf_pkg::cpx_t  st_mem   [prnf_pkg::MAX_POLES];

	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
		coef_rdata <= coef_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_waddr] <= st_wdata;
		st_rdata <= st_mem[raddr];
	end
endmodule

/* rtl/pole_residue_noise_filter_top.sv */
// Top level: pole-residue noise filter, sequencer, multiplier datapath and memories.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | action .. first_sample
//  out     | output    | out_valid/out_stall| noise_value, saturated
//  cfg     | input     | cfg_we             | cfg_data (pole_count)
// A load is written to the coefficient memory when accepted. For each of N active poles a sample
// does a memory read, then the state, update and residue products on one shared multiplier pair.
// After reset a clearing pass zeroes the pole states of all MAX_POLES poles; in_stall is high.
// The result waits in an output register; in_stall stays high through a sample and while
// the result is untaken.
module pole_residue_noise_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [3:0]  pole_index,
	input  logic signed [31:0] decay_re,
	input  logic signed [31:0] decay_im,
	input  logic signed [31:0] gain_re,
	input  logic signed [31:0] gain_im,
	input  logic signed [31:0] start_re,
	input  logic signed [31:0] start_im,
	input  logic signed [31:0] residue_re,
	input  logic signed [31:0] residue_im,
	input  logic signed [31:0] drive_current,
	input  logic        first_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] noise_value,
	output logic        saturated
);
	localparam int IW = prnf_pkg::IDX_W;

	prnf_pkg::state_t state_q, state_d;
	logic [4:0]    count_q;
	logic [IW:0]   clr_q;
	logic          clr_done;
	logic [IW:0]   pole_q, nact;
	logic [2:0]    step_q;
	logic signed [31:0] u_q;
	logic          first_q;
	prnf_pkg::coef_t coef_rd;
	prnf_pkg::cpx_t  st_rd, x_q;
	prnf_pkg::acc_t  acc_re_q, acc_im_q, sum_q;
	logic          in_acc;
	logic          coef_we, st_we;
	prnf_pkg::coef_t coef_wd;
	prnf_pkg::cpx_t  st_wd, rs_re, rs_im, rs_sum, rs_c0, rs_c1;
	logic signed [31:0] ma0, mb0, ma1, mb1;
	prnf_pkg::prod_t p0_q, p1_q;
	logic [IW-1:0] raddr;

	assign clr_done = clr_q[IW];
	assign nact = (count_q > 5'(prnf_pkg::MAX_POLES)) ? (IW+1)'(prnf_pkg::MAX_POLES)
		: (IW+1)'(count_q);
	assign in_stall = !clr_done || state_q != prnf_pkg::ST_IDLE || out_valid;
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		coef_wd.a_re = prnf_pkg::coef_ext(decay_re);
		coef_wd.a_im = prnf_pkg::coef_ext(decay_im);
		coef_wd.b_re = prnf_pkg::coef_ext(gain_re);
		coef_wd.b_im = prnf_pkg::coef_ext(gain_im);
		coef_wd.c_re = prnf_pkg::coef_ext(start_re);
		coef_wd.c_im = prnf_pkg::coef_ext(start_im);
		coef_wd.r_re = prnf_pkg::coef_ext(residue_re);
		coef_wd.r_im = prnf_pkg::coef_ext(residue_im);
	end
	assign coef_we = in_acc && !action;
	assign raddr = pole_q[IW-1:0];

	// START 0..2: latch state, start product; UPDATE 0..3: three product pairs;
	// RESID 0..2: state writeback and residue products
	assign rs_re  = prnf_pkg::round_sat(acc_re_q);
	assign rs_im  = prnf_pkg::round_sat(acc_im_q);
	assign rs_sum = prnf_pkg::round_sat(sum_q);
	assign rs_c0  = prnf_pkg::round_sat(prnf_pkg::acc_t'(p0_q));
	assign rs_c1  = prnf_pkg::round_sat(prnf_pkg::acc_t'(p1_q));

	always_comb begin
		st_we = 1'b0;
		st_wd.re = rs_re.re;
		st_wd.im = rs_im.re;
		if (!clr_done) begin
			st_we = 1'b1;
			st_wd = '0;
		end else if (state_q == prnf_pkg::ST_RESID && step_q == 3'd0) begin
			st_we = 1'b1;
		end
	end

	prnf_mem u_mem (
		.clk(clk), .coef_we(coef_we), .coef_waddr(pole_index), .coef_wdata(coef_wd),
		.st_we(st_we), .st_waddr(clr_done ? raddr : clr_q[IW-1:0]), .st_wdata(st_wd),
		.raddr(raddr), .coef_rdata(coef_rd), .st_rdata(st_rd)
	);

	// operand select for the two shared multipliers
	always_comb begin
		ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
		unique case (state_q)
			prnf_pkg::ST_START: begin
				ma0 = coef_rd.c_re; mb0 = u_q; ma1 = coef_rd.c_im; mb1 = u_q;
			end
			prnf_pkg::ST_UPDATE: begin
				case (step_q)
					3'd0: begin ma0 = coef_rd.a_re; mb0 = x_q.re; ma1 = coef_rd.a_re; mb1 = x_q.im; end
					3'd1: begin ma0 = coef_rd.a_im; mb0 = x_q.im; ma1 = coef_rd.a_im; mb1 = x_q.re; end
					default: begin ma0 = coef_rd.b_re; mb0 = u_q; ma1 = coef_rd.b_im; mb1 = u_q; end
				endcase
			end
			prnf_pkg::ST_RESID: begin
				ma0 = coef_rd.r_re; mb0 = rs_re.re; ma1 = coef_rd.r_im; mb1 = rs_im.re;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		p0_q <= ma0 * mb0;
		p1_q <= ma1 * mb1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prnf_pkg::ST_IDLE;
			count_q <= 5'd1;
			clr_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) count_q <= cfg_data;
			if (!clr_done) clr_q <= clr_q + 1'b1;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == prnf_pkg::ST_DONE) out_valid <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prnf_pkg::ST_IDLE:   if (in_acc && action) state_d = prnf_pkg::ST_READ;
			prnf_pkg::ST_READ:
				state_d = (pole_q >= nact) ? prnf_pkg::ST_DONE : prnf_pkg::ST_START;
			prnf_pkg::ST_START:  if (step_q == 3'd2) state_d = prnf_pkg::ST_UPDATE;
			prnf_pkg::ST_UPDATE: if (step_q == 3'd3) state_d = prnf_pkg::ST_RESID;
			prnf_pkg::ST_RESID:  if (step_q == 3'd2) state_d = prnf_pkg::ST_READ;
			prnf_pkg::ST_DONE:   state_d = prnf_pkg::ST_IDLE;
			default:             state_d = prnf_pkg::ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q != state_d) step_q <= '0;
		else step_q <= step_q + 3'd1;
		unique case (state_q)
			prnf_pkg::ST_IDLE: begin
				pole_q <= '0; u_q <= drive_current; first_q <= first_sample; sum_q <= '0;
			end
			prnf_pkg::ST_START: begin
				if (step_q == 3'd0) x_q <= st_rd;
				if (step_q == 3'd2 && first_q) begin
					x_q.re <= rs_c0.re;
					x_q.im <= rs_c1.re;
				end
				acc_re_q <= '0; acc_im_q <= '0;
			end
			prnf_pkg::ST_UPDATE: begin
				// products are registered and land in the cycle after their operands
				if (step_q == 3'd1) begin
					acc_re_q <= acc_re_q + prnf_pkg::acc_t'(p0_q);
					acc_im_q <= acc_im_q + prnf_pkg::acc_t'(p1_q);
				end else if (step_q == 3'd2) begin
					acc_re_q <= acc_re_q - prnf_pkg::acc_t'(p0_q);
					acc_im_q <= acc_im_q + prnf_pkg::acc_t'(p1_q);
				end else if (step_q == 3'd3) begin
					acc_re_q <= acc_re_q + prnf_pkg::acc_t'(p0_q);
					acc_im_q <= acc_im_q + prnf_pkg::acc_t'(p1_q);
				end
			end
			prnf_pkg::ST_RESID: begin
				if (step_q == 3'd1)
					sum_q <= sum_q + prnf_pkg::acc_t'(p0_q) - prnf_pkg::acc_t'(p1_q);
				if (step_q == 3'd2) pole_q <= pole_q + 1'b1;
			end
			prnf_pkg::ST_DONE: begin
				noise_value <= rs_sum.re;
				saturated   <= rs_sum.im[0];
			end
			default: ;
		endcase
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != prnf_pkg::ST_IDLE |-> in_stall)
		else $error("input accepted during sample");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == prnf_pkg::ST_DONE)
		else $error("result without completed sample");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> state_q == prnf_pkg::ST_IDLE && in_stall)
		else $error("work during clearing pass");
endmodule

/* tb/tb.sv */
// Self-checking testbench for the pole-residue noise filter top level.
module tb;
	typedef prnf_pkg::word_t word_t;

	typedef logic signed [79:0] wide_t;

	typedef struct {
		logic        act;
		logic [3:0]  idx;
		word_t       cf[8];
		word_t       cur;
		logic        first;
	} item_t;

	typedef struct {
		word_t value;
		logic  clip;
	} noise_t;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;
	localparam int   SETTLE     = 120;
	localparam int   LIMIT      = 2000000;

	logic clk, arst_n;
	logic cfg_we;
	logic [4:0] cfg_data;
	logic in_valid, in_stall;
	logic action, first_sample;
	logic [3:0] pole_index;
	logic signed [31:0] decay_re, decay_im, gain_re, gain_im;
	logic signed [31:0] start_re, start_im, residue_re, residue_im, drive_current;
	logic out_valid, out_stall;
	logic signed [31:0] noise_value;
	logic saturated;

	pole_residue_noise_filter_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .pole_index(pole_index),
		.decay_re(decay_re), .decay_im(decay_im),
		.gain_re(gain_re), .gain_im(gain_im),
		.start_re(start_re), .start_im(start_im),
		.residue_re(residue_re), .residue_im(residue_im),
		.drive_current(drive_current), .first_sample(first_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.noise_value(noise_value), .saturated(saturated)
	);

	item_t  pending[$];
	noise_t expected_noise[$];

	// filter model state
	word_t      pole_cf[16][8];
	word_t      st_re[16], st_im[16];
	logic [4:0] active_poles;

	int  errors = 0;
	int  cycles = 0;
	int  gap_max = 6;
	int  stall_max = 6;
	int  samples_out = 0;
	bit  in_acc = 0;
	bit  out_acc = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic wide_t mul(input word_t p, input word_t q);
		wide_t a, b;
		a = p;
		b = q;
		return a * b;
	endfunction

	// round half up from 2^-40 to Q16.16, then clamp to 32 bits
	function automatic word_t round_clamp(input wide_t s, output logic clip);
		wide_t t;
		t = (s + (wide_t'(1) <<< 23)) >>> 24;
		clip = 1'b1;
		if (t > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
		if (t < -wide_t'(33'sh080000000)) return 32'sh80000000;
		clip = 1'b0;
		return t[31:0];
	endfunction

	function automatic noise_t filter_sample(input word_t u, input logic first);
		noise_t r;
		wide_t  acc, are, aim;
		word_t  xr, xi;
		logic   c;
		int     n;
		n = (active_poles > 16) ? 16 : active_poles;
		acc = '0;
		for (int i = 0; i < n; i++) begin
			xr = st_re[i];
			xi = st_im[i];
			if (first) begin
				xr = round_clamp(mul(pole_cf[i][4], u), c);
				xi = round_clamp(mul(pole_cf[i][5], u), c);
			end
			are = mul(pole_cf[i][0], xr) - mul(pole_cf[i][1], xi) + mul(pole_cf[i][2], u);
			aim = mul(pole_cf[i][0], xi) + mul(pole_cf[i][1], xr) + mul(pole_cf[i][3], u);
			st_re[i] = round_clamp(are, c);
			st_im[i] = round_clamp(aim, c);
			acc += mul(pole_cf[i][6], st_re[i]) - mul(pole_cf[i][7], st_im[i]);
		end
		r.value = round_clamp(acc, r.clip);
		return r;
	endfunction

	// input side: model update on every accepted transaction and config write
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			in_acc = in_valid && !in_stall;
			if (cfg_we)
				active_poles = cfg_data;
			if (in_acc) begin
				if (action == ACT_LOAD) begin
					pole_cf[pole_index] = '{decay_re, decay_im, gain_re, gain_im,
						start_re, start_im, residue_re, residue_im};
				end else begin
					expected_noise.insert(expected_noise.size(),
						filter_sample(drive_current, first_sample));
				end
			end
		end
	end

	// output side: compare each transaction with the oldest expectation
	always @(posedge clk) begin
		noise_t e;
		out_acc = out_valid && !out_stall;
		if (out_acc) begin
			samples_out++;
			if (expected_noise.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h sat %b", noise_value, saturated);
			end else begin
				e = expected_noise.pop_front();
				if (noise_value !== e.value || saturated !== e.clip) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h sat %b, got %h sat %b",
							e.value, e.clip, noise_value, saturated);
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		item_t it;
		logic  vld;
		int    gap;
		if (!arst_n) begin
			gap = 0;
		end else if (!in_valid || in_acc) begin
			vld = 1'b0;
			if (gap > 0) begin
				gap--;
			end else if (pending.size() > 0) begin
				it = pending.pop_front();
				action <= it.act;
				pole_index <= it.idx;
				decay_re <= it.cf[0]; decay_im <= it.cf[1];
				gain_re <= it.cf[2]; gain_im <= it.cf[3];
				start_re <= it.cf[4]; start_im <= it.cf[5];
				residue_re <= it.cf[6]; residue_im <= it.cf[7];
				drive_current <= it.cur;
				first_sample <= it.first;
				vld = 1'b1;
				gap = $urandom_range(0, gap_max);
			end
			in_valid <= vld;
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		int  wait_cnt;
		int  long_cnt;
		bit  long_done;
		if (!arst_n) begin
			wait_cnt = 0;
			long_cnt = 0;
			long_done = 0;
		end else begin
			if (!long_done && samples_out >= 100) begin
				long_done = 1;
				long_cnt = 600;
			end
			if (out_acc)
				wait_cnt = $urandom_range(0, stall_max);
			out_stall <= (wait_cnt > 0) || (long_cnt > 0);
			if (wait_cnt > 0) wait_cnt--;
			if (long_cnt > 0) long_cnt--;
		end
	end

	function automatic word_t mid_coef();
		return int'($urandom_range(0, 33554432)) - 16777216;
	endfunction

	function automatic item_t load_item(input logic [3:0] k, input bit full);
		item_t it;
		it.act = ACT_LOAD;
		it.idx = k;
		for (int j = 0; j < 8; j++)
			it.cf[j] = full ? word_t'($urandom) : mid_coef();
		it.cur = word_t'($urandom);
		it.first = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t sample_item(input word_t u, input logic first);
		item_t it;
		it.act = ACT_SAMPLE;
		it.idx = 4'($urandom);
		for (int j = 0; j < 8; j++)
			it.cf[j] = word_t'($urandom);
		it.cur = u;
		it.first = first;
		return it;
	endfunction

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_noise.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_poles(input logic [4:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		item_t it;
		logic [4:0] settings[8];
		word_t u;
		arst_n = 0;
		cfg_we = 0; cfg_data = '0;
		in_valid = 0; out_stall = 0;
		action = 0; pole_index = '0; first_sample = 0;
		decay_re = 0; decay_im = 0; gain_re = 0; gain_im = 0;
		start_re = 0; start_im = 0; residue_re = 0; residue_im = 0; drive_current = 0;
		active_poles = 5'd1;
		for (int i = 0; i < 16; i++) begin
			st_re[i] = 0;
			st_im[i] = 0;
			for (int j = 0; j < 8; j++)
				pole_cf[i][j] = 0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1;

		// directed: every pole loaded before any sample touches it
		set_poles(5'd16);
		it = load_item(4'd0, 1'b0);
		for (int j = 0; j < 8; j++) it.cf[j] = 32'sh7fffffff;
		pending.insert(pending.size(), it);
		it = load_item(4'd1, 1'b0);
		for (int j = 0; j < 8; j++) it.cf[j] = 32'sh80000000;
		pending.insert(pending.size(), it);
		for (int k = 2; k < 15; k++)
			pending.insert(pending.size(), load_item(4'(k), 1'b0));
		pending.insert(pending.size(), load_item(4'd15, 1'b1));
		pending.insert(pending.size(), sample_item(32'sh7fffffff, 1'b1));
		pending.insert(pending.size(), sample_item(32'sh80000000, 1'b0));
		pending.insert(pending.size(), sample_item(32'sh80000000, 1'b1));
		pending.insert(pending.size(), sample_item(32'sh00000000, 1'b0));
		pending.insert(pending.size(), sample_item(32'sh00010000, 1'b1));
		pending.insert(pending.size(), sample_item(32'sh7fffffff, 1'b0));
		drain();
		// tame the extreme poles so later sums do not all clip
		for (int k = 0; k < 2; k++)
			pending.insert(pending.size(), load_item(4'(k), 1'b0));

		settings = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0};
		for (int p = 4; p < 8; p++)
			settings[p] = 5'($urandom_range(0, 31));
		for (int p = 0; p < 8; p++) begin
			drain();
			gap_max = (p % 3 == 1) ? 0 : 6;
			stall_max = (p % 3 == 2) ? 0 : 6;
			set_poles(settings[p]);
			for (int n = 0; n < 115; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					pending.insert(pending.size(),
						load_item(4'($urandom), $urandom_range(0, 3) == 0));
				end else begin
					u = ($urandom_range(0, 7) == 0) ? word_t'($urandom)
						: word_t'(int'($urandom_range(0, 2097152)) - 1048576);
					pending.insert(pending.size(),
						sample_item(u, $urandom_range(0, 9) == 0));
				end
			end
		end
		drain();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/prnf_pkg.sv
rtl/prnf_mem.sv
rtl/pole_residue_noise_filter_top.sv
tb/tb.sv
